// ===== hw/rtl/humidity_temp_frame_decoder_core_macros.svh =====
// Assertion macros shared by the frame decoder checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define HTFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame decoder check failed");

// next-cycle implication, checked outside reset
`define HTFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame decoder check failed");

`endif

// ===== hw/rtl/htfd_pkg.sv =====
// Package for the humidity / temperature frame decoder.
// Holds byte position codes, conversion constants and the CRC-8 byte update.
// No dependencies.
package htfd_pkg;

    // position of the next byte within a sensor frame
    typedef enum logic [1:0] {
        POS_HIGH  = 2'd0,
        POS_LOW   = 2'd1,
        POS_CHECK = 2'd2
    } pos_t;

    localparam int ByteW  = 8;
    localparam int ValueW = 15;
    localparam int ScaleW = 15;
    localparam int RawW   = 16;
    localparam int ProdW  = ScaleW + RawW;

    // CRC-8, x^8+x^5+x^4+1, init 0
    localparam logic [ByteW-1:0] CrcPoly = 8'h31;
    localparam logic [ByteW-1:0] CrcInit = 8'h00;

    // conversion: value = (scale * S) >> 16 - offset, hundredths of a unit
    localparam logic [ScaleW-1:0]   TempScale  = 15'd17572;
    localparam logic [ScaleW-1:0]   RhScale    = 15'd12500;
    localparam logic signed [15:0]  TempOffset = 16'sd4685;
    localparam logic signed [15:0]  RhOffset   = 16'sd600;

    // one byte of the CRC, bit-serial over eight narrow steps
    function automatic logic [ByteW-1:0] crc8_feed(
        input logic [ByteW-1:0] crc_in,
        input logic [ByteW-1:0] data_in
    );
        logic [ByteW-1:0] c;
        c = crc_in ^ data_in;
        for (int i = 0; i < ByteW; i++) begin
            if (c[ByteW-1])
            begin
                c = {c[ByteW-2:0], 1'b0} ^ CrcPoly;
            end
            else
            begin
                c = {c[ByteW-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder_core.sv =====
// Channel | direction | handshake          | word
// in      | sink      | in_valid/in_stall  | rx_byte, frame_start, humidity_frame
// out     | source    | out_valid/out_stall| measured_value, crc_mismatch, value_is_humidity
//
// One input word per cycle while in_stall is low; the result is registered on the cycle
// after the checksum word. CRC update and the 15x16 conversion multiply are combinational
// between the frame registers and the result register.
// Reset clears the frame registers and the result valid; the result word is not reset.
// in_stall rises only while a result is held and out_stall is high.
//
// Top level of the sensor frame decoder; uses htfd_pkg.
module humidity_temp_frame_decoder_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [htfd_pkg::ByteW-1:0]        rx_byte,
    input  logic                              frame_start,
    input  logic                              humidity_frame,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [htfd_pkg::ValueW-1:0] measured_value,
    output logic                              crc_mismatch,
    output logic                              value_is_humidity
);

    htfd_pkg::pos_t                 pos_reg, pos_next;
    logic [htfd_pkg::ByteW-1:0]     crc_reg, crc_next;
    logic [htfd_pkg::ByteW-1:0]     high_reg, high_next;
    logic [htfd_pkg::ByteW-1:0]     low_reg, low_next;
    logic                           kind_reg, kind_next;

    logic                           out_valid_reg, out_valid_next;
    logic signed [htfd_pkg::ValueW-1:0] value_reg, value_next;
    logic                           mismatch_reg, mismatch_next;
    logic                           is_hum_reg, is_hum_next;

    logic                           accept_in;
    logic                           result_fire;
    logic [htfd_pkg::RawW-1:0]      raw_s;
    logic [htfd_pkg::ScaleW-1:0]    scale_sel;
    logic signed [15:0]             offset_sel;
    logic [htfd_pkg::ProdW-1:0]     product;
    logic signed [15:0]             converted;

    // handshake: hold input only while a result is stuck downstream
    assign in_stall  = out_valid_reg & out_stall;
    assign accept_in = in_valid & ~in_stall;

    // next byte position
    always_comb
    begin
        pos_next = pos_reg;
        if (accept_in)
        begin
            if (frame_start)
            begin
                pos_next = htfd_pkg::POS_LOW;
            end
            else
            begin
                case (pos_reg)
                    htfd_pkg::POS_LOW:   pos_next = htfd_pkg::POS_CHECK;
                    htfd_pkg::POS_CHECK: pos_next = htfd_pkg::POS_HIGH;
                    default:             pos_next = htfd_pkg::POS_LOW;
                endcase
            end
        end
    end

    // frame datapath: byte capture and running CRC
    always_comb
    begin
        crc_next    = crc_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        kind_next   = kind_reg;
        result_fire = 1'b0;
        if (accept_in)
        begin
            if (frame_start)
            begin
                high_next = rx_byte;
                kind_next = humidity_frame;
                crc_next  = htfd_pkg::crc8_feed(htfd_pkg::CrcInit, rx_byte);
            end
            else
            begin
                case (pos_reg)
                    htfd_pkg::POS_LOW:
                    begin
                        low_next = rx_byte;
                        crc_next = htfd_pkg::crc8_feed(crc_reg, rx_byte);
                    end
                    htfd_pkg::POS_CHECK:
                    begin
                        crc_next    = htfd_pkg::CrcInit;
                        result_fire = 1'b1;
                    end
                    default:
                    begin
                        high_next = rx_byte;
                        kind_next = humidity_frame;
                        crc_next  = htfd_pkg::crc8_feed(htfd_pkg::CrcInit, rx_byte);
                    end
                endcase
            end
        end
    end

    // conversion: status bits cleared, one multiply, floor by shift
    assign raw_s      = {high_reg, low_reg[htfd_pkg::ByteW-1:2], 2'b00};
    assign scale_sel  = kind_reg ? htfd_pkg::RhScale : htfd_pkg::TempScale;
    assign offset_sel = kind_reg ? htfd_pkg::RhOffset : htfd_pkg::TempOffset;
    assign product    = htfd_pkg::ProdW'(scale_sel) * htfd_pkg::ProdW'(raw_s);
    assign converted  = $signed({1'b0, product[htfd_pkg::ProdW-1:htfd_pkg::RawW]})
                        - offset_sel;

    // result register: load on checksum word, clear when taken
    always_comb
    begin
        value_next    = value_reg;
        mismatch_next = mismatch_reg;
        is_hum_next   = is_hum_reg;
        out_valid_next = out_valid_reg & out_stall;
        if (result_fire)
        begin
            out_valid_next = 1'b1;
            value_next     = converted[htfd_pkg::ValueW-1:0];
            mismatch_next  = (crc_reg != rx_byte);
            is_hum_next    = kind_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= htfd_pkg::POS_HIGH;
            crc_reg       <= htfd_pkg::CrcInit;
            high_reg      <= '0;
            low_reg       <= '0;
            kind_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        mismatch_reg <= mismatch_next;
        is_hum_reg   <= is_hum_next;
    end

    assign out_valid         = out_valid_reg;
    assign measured_value    = value_reg;
    assign crc_mismatch      = mismatch_reg;
    assign value_is_humidity = is_hum_reg;

endmodule

// ===== hw/rtl/htfd_checker.sv =====
// Port-level checks for the sensor frame decoder, bound to its top level.
// Depends on humidity_temp_frame_decoder_core_macros.svh and htfd_pkg.
`include "humidity_temp_frame_decoder_core_macros.svh"

module htfd_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic signed [htfd_pkg::ValueW-1:0] measured_value,
    input logic                               crc_mismatch,
    input logic                               value_is_humidity
);

    logic [htfd_pkg::ValueW+1:0] out_word;
    logic                        temp_in_range;
    logic                        rh_in_range;

    // whole result word, and the range of each reading kind
    assign out_word      = {measured_value, crc_mismatch, value_is_humidity};
    assign temp_in_range = measured_value >= -15'sd4685 && measured_value <= 15'sd12885;
    assign rh_in_range   = measured_value >= -15'sd600 && measured_value <= 15'sd11899;

    // a held result keeps its word
    `HTFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // input backs up only behind a stuck result
    `HTFD_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // temperature readings stay in the sensor range
    `HTFD_ASSERT_NOW(a_temp_range, out_valid && !value_is_humidity, temp_in_range)

    // humidity readings stay in their range
    `HTFD_ASSERT_NOW(a_rh_range, out_valid && value_is_humidity, rh_in_range)

endmodule

bind humidity_temp_frame_decoder_core htfd_checker u_htfd_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .measured_value    (measured_value),
    .crc_mismatch      (crc_mismatch),
    .value_is_humidity (value_is_humidity)
);
